### src/dda_pkg.sv
// Shared types, constants and state codes for the DDA line rasterizer.
`timescale 1ns / 1ps
`default_nettype none

package dda_pkg;

  // Default sizes of the fixed-point datapath
  localparam int COORD_BITS_DEF = 10;
  localparam int FRAC_BITS_DEF  = 16;

  // Width of the coordinate fields on the ports
  localparam int PIX_W = 10;

  // Request codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [PIX_W-1:0] start_x;
    logic [PIX_W-1:0] start_y;
    logic [PIX_W-1:0] end_x;
    logic [PIX_W-1:0] end_y;
  } req_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    logic             last_point;
  } pix_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START_X,
    ST_WAIT_X,
    ST_START_Y,
    ST_WAIT_Y,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

### src/dda_line_rasterizer.sv
// DDA line rasterizer: load sequencer, shared divider and point stepper.
//
//   channel  | direction | handshake                | payload
//   ---------+-----------+--------------------------+-----------------------
//   request  | in        | in_valid_i / in_ready_o  | in_i  (req_t)
//   point    | out       | out_valid_o / out_ready_i| out_o (pix_t)
//
// A tick transfer's point sits in the output register the next cycle. A load
// runs the one divider twice, for x then for y, at one quotient bit per
// cycle; a zero-length load skips the divider and goes straight to emit.
// The request side is not ready during a load, or while a point waits in the
// output register and the point side stalls. Reset clears the sequencer, the
// line-active flag and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module dda_line_rasterizer #(
  parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire dda_pkg::req_t in_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output dda_pkg::pix_t      out_o
);
  import dda_pkg::*;

  localparam int POS_W = COORD_BITS + 1 + FRAC_BITS;
  localparam int NUM_W = COORD_BITS + FRAC_BITS;
  localparam int EXT_W = (COORD_BITS > PIX_W) ? COORD_BITS : PIX_W;
  localparam logic [POS_W:0] HALF =
    {{(POS_W + 1 - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};

  state_e state_q, state_d;

  logic                  active_q, active_d;
  logic                  out_valid_q, out_valid_d;
  pix_t                  out_q;
  logic [POS_W-1:0]      pos_x_q, pos_y_q;
  logic [POS_W-1:0]      inc_x_q, inc_y_q;
  logic [COORD_BITS-1:0] steps_left_q;
  logic [COORD_BITS-1:0] mag_x_q, mag_y_q;
  logic                  neg_x_q, neg_y_q;

  logic                  in_xfer, load_xfer, tick_xfer, emit_fire, out_free;
  logic [EXT_W-1:0]      sx_ext, sy_ext, ex_ext, ey_ext;
  logic [COORD_BITS-1:0] sx, sy, ex, ey;
  logic [COORD_BITS:0]   dx, dy, dx_neg, dy_neg;
  logic [COORD_BITS-1:0] mag_x, mag_y, steps;
  logic [POS_W-1:0]      sum_x, sum_y, src_x, src_y;
  logic [COORD_BITS-1:0] pix_x, pix_y;
  logic [EXT_W-1:0]      pix_x_ext, pix_y_ext;
  logic                  last_tick;

  logic                  div_start, div_done;
  logic [NUM_W-1:0]      div_dividend, div_quotient;
  logic [POS_W-1:0]      quo_ext, inc_new;

  // Round half up to the nearest pixel and clamp to the coordinate range
  function automatic logic [COORD_BITS-1:0] round_pix(input logic [POS_W-1:0] pos);
    logic [POS_W:0] v;
    v = {pos[POS_W-1], pos} + HALF;
    if (v[POS_W]) begin
      round_pix = '0;
    end else if (v[POS_W-1:FRAC_BITS+COORD_BITS] != '0) begin
      round_pix = '1;
    end else begin
      round_pix = v[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
    end
  endfunction

  // Handshake decode
  assign out_free  = !out_valid_q || out_ready_i;
  assign in_xfer   = in_valid_i && in_ready_o;
  assign load_xfer = in_xfer && (in_i.req_type == REQ_LOAD);
  assign tick_xfer = in_xfer && (in_i.req_type == REQ_TICK) && active_q;
  assign emit_fire = (state_q == ST_EMIT) && out_free;

  // Take coordinates modulo the coordinate range
  always_comb begin
    sx_ext = EXT_W'(in_i.start_x);
    sy_ext = EXT_W'(in_i.start_y);
    ex_ext = EXT_W'(in_i.end_x);
    ey_ext = EXT_W'(in_i.end_y);
    sx = sx_ext[COORD_BITS-1:0];
    sy = sy_ext[COORD_BITS-1:0];
    ex = ex_ext[COORD_BITS-1:0];
    ey = ey_ext[COORD_BITS-1:0];
  end

  // Deltas, magnitudes and step count of a new line
  always_comb begin
    dx     = {1'b0, ex} - {1'b0, sx};
    dy     = {1'b0, ey} - {1'b0, sy};
    dx_neg = -dx;
    dy_neg = -dy;
    mag_x  = dx[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    mag_y  = dy[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
    steps  = (mag_x > mag_y) ? mag_x : mag_y;
  end

  // Next position and the point to show
  always_comb begin
    sum_x     = pos_x_q + inc_x_q;
    sum_y     = pos_y_q + inc_y_q;
    src_x     = (state_q == ST_EMIT) ? pos_x_q : sum_x;
    src_y     = (state_q == ST_EMIT) ? pos_y_q : sum_y;
    pix_x     = round_pix(src_x);
    pix_y     = round_pix(src_y);
    pix_x_ext = EXT_W'(pix_x);
    pix_y_ext = EXT_W'(pix_y);
    last_tick = (steps_left_q == COORD_BITS'(1));
  end

  // Feed the shared divider and sign its quotient
  always_comb begin
    div_dividend = (state_q == ST_START_X) ? {mag_x_q, {FRAC_BITS{1'b0}}}
                                           : {mag_y_q, {FRAC_BITS{1'b0}}};
    quo_ext = {1'b0, div_quotient};
    inc_new = ((state_q == ST_WAIT_X) ? neg_x_q : neg_y_q) ? -quo_ext : quo_ext;
  end

  dda_divider #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (steps_left_q),
    .quotient_o (div_quotient),
    .done_o     (div_done)
  );

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (load_xfer) begin
          state_d = (steps == '0) ? ST_EMIT : ST_START_X;
        end
      end
      ST_START_X: state_d = ST_WAIT_X;
      ST_WAIT_X: begin
        if (div_done) state_d = ST_START_Y;
      end
      ST_START_Y: state_d = ST_WAIT_Y;
      ST_WAIT_Y: begin
        if (div_done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    unique case (state_q)
      ST_IDLE:    in_ready_o = out_free;
      ST_START_X: div_start  = 1'b1;
      ST_START_Y: div_start  = 1'b1;
      ST_WAIT_X, ST_WAIT_Y, ST_EMIT: begin
        in_ready_o = 1'b0;
      end
      default:    in_ready_o = 1'b0;
    endcase
  end

  // Line activity and output valid
  always_comb begin
    active_d = active_q;
    if (load_xfer) begin
      active_d = (steps != '0);
    end else if (tick_xfer) begin
      active_d = !last_tick;
    end
    if (emit_fire || tick_xfer) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && !out_ready_i;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Load the line, capture increments, step the position, fill the output
  always_ff @(posedge clk_i) begin
    if (load_xfer) begin
      pos_x_q      <= {1'b0, sx, {FRAC_BITS{1'b0}}};
      pos_y_q      <= {1'b0, sy, {FRAC_BITS{1'b0}}};
      inc_x_q      <= '0;
      inc_y_q      <= '0;
      steps_left_q <= steps;
      mag_x_q      <= mag_x;
      mag_y_q      <= mag_y;
      neg_x_q      <= dx[COORD_BITS];
      neg_y_q      <= dy[COORD_BITS];
    end else if (tick_xfer) begin
      pos_x_q      <= sum_x;
      pos_y_q      <= sum_y;
      steps_left_q <= steps_left_q - 1'b1;
    end
    if (div_done && (state_q == ST_WAIT_X)) inc_x_q <= inc_new;
    if (div_done && (state_q == ST_WAIT_Y)) inc_y_q <= inc_new;
    if (emit_fire || tick_xfer) begin
      out_q.pixel_x    <= pix_x_ext[PIX_W-1:0];
      out_q.pixel_y    <= pix_y_ext[PIX_W-1:0];
      out_q.last_point <= emit_fire ? !active_q : last_tick;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef NO_ASSERTIONS
  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == ST_IDLE))
    else $error("request side ready outside idle");

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_WAIT_X || state_q == ST_WAIT_Y))
    else $error("divider finished outside a wait state");

  a_active_has_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && active_q) |-> (steps_left_q != '0))
    else $error("active line with no steps left");

  a_tick_gives_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_xfer |=> out_valid_q)
    else $error("tick on an active line gave no point");

  a_emit_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && !out_free) |=> (state_q == ST_EMIT))
    else $error("start point dropped while output stalled");
`endif

endmodule

`default_nettype wire

### src/dda_divider.sv
// Restoring shift-subtract divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module dda_divider #(
  parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [COORD_BITS+FRAC_BITS-1:0]  dividend_i,
  input  wire logic [COORD_BITS-1:0]            divisor_i,
  output logic      [COORD_BITS+FRAC_BITS-1:0]  quotient_o,
  output logic                                  done_o
);
  import dda_pkg::*;

  localparam int NUM_W = COORD_BITS + FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  done_q, done_d;
  logic [NUM_W-1:0]      quo_q, quo_d;
  logic [COORD_BITS-1:0] rem_q, rem_d;
  logic [COORD_BITS-1:0] den_q, den_d;
  logic [COORD_BITS:0]   trial;
  logic [COORD_BITS:0]   diff;

  // Shift in the next dividend bit and try to subtract the divisor
  always_comb begin
    trial = {rem_q, quo_q[NUM_W-1]};
    diff  = trial - {1'b0, den_q};
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    done_d = 1'b0;
    if (start_i) begin
      cnt_d = CNT_W'(NUM_W);
      quo_d = dividend_i;
      rem_d = '0;
      den_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_W'(1));
      if (diff[COORD_BITS]) begin
        rem_d = trial[COORD_BITS-1:0];
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end else begin
        rem_d = diff[COORD_BITS-1:0];
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end
    end
  end

  // Hold the step count and the done pulse under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // Advance the working registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

`default_nettype wire

### verif/tb_dda_line_rasterizer.sv
// Self-checking testbench for the DDA line rasterizer: directed and random lines.
`timescale 1ns / 1ps

// Tracks the line being drawn and queues the points the block owes us
class line_trace_model;
  localparam int FB    = dda_pkg::FRAC_BITS_DEF;
  localparam int CB    = dda_pkg::COORD_BITS_DEF;
  localparam int POS_W = CB + 1 + FB;

  logic signed [POS_W-1:0] pos_x, pos_y;
  logic signed [POS_W-1:0] inc_x, inc_y;
  logic [10:0]             steps_left;
  bit                      drawing;
  dda_pkg::pix_t           owed_points[$];
  int                      mismatches;

  function new();
    pos_x      = '0;
    pos_y      = '0;
    inc_x      = '0;
    inc_y      = '0;
    steps_left = '0;
    drawing    = 1'b0;
    mismatches = 0;
  endfunction

  // Round half up to a pixel, then clamp to the coordinate range
  function logic [dda_pkg::PIX_W-1:0] round_pixel(logic signed [POS_W-1:0] pos);
    longint v;
    v = longint'(pos) + (longint'(1) <<< (FB - 1));
    if (v < 0) return '0;
    v = v >>> FB;
    if (v > (longint'(1) << CB) - 1) v = (longint'(1) << CB) - 1;
    return v[dda_pkg::PIX_W-1:0];
  endfunction

  function void owe_point(bit last);
    dda_pkg::pix_t p;
    p.pixel_x    = round_pixel(pos_x);
    p.pixel_y    = round_pixel(pos_y);
    p.last_point = last;
    owed_points.push_back(p);
  endfunction

  // Advance the line on one request transfer
  function void take_request(dda_pkg::req_t r);
    longint sx, sy, ex, ey, dx, dy, ax, ay, steps, one;
    one = longint'(1) << FB;
    if (r.req_type == dda_pkg::REQ_LOAD) begin
      sx = longint'(r.start_x);
      sy = longint'(r.start_y);
      ex = longint'(r.end_x);
      ey = longint'(r.end_y);
      dx = ex - sx;
      dy = ey - sy;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      steps = (ax > ay) ? ax : ay;
      pos_x = POS_W'(sx * one);
      pos_y = POS_W'(sy * one);
      if (steps == 0) begin
        inc_x      = '0;
        inc_y      = '0;
        steps_left = '0;
        drawing    = 1'b0;
        owe_point(1'b1);
      end else begin
        // signed division truncates toward zero
        inc_x      = POS_W'((dx * one) / steps);
        inc_y      = POS_W'((dy * one) / steps);
        steps_left = 11'(steps);
        drawing    = 1'b1;
        owe_point(1'b0);
      end
    end else if (drawing) begin
      pos_x      = pos_x + inc_x;
      pos_y      = pos_y + inc_y;
      steps_left = steps_left - 11'd1;
      if (steps_left == 11'd0) begin
        drawing = 1'b0;
        owe_point(1'b1);
      end else begin
        owe_point(1'b0);
      end
    end
  endfunction

  // Compare one point transfer against the oldest owed point
  function void check_point(dda_pkg::pix_t got);
    dda_pkg::pix_t want;
    if (owed_points.size() == 0) begin
      $display("%0t: unexpected point x=%0d y=%0d last=%0d", $time,
               got.pixel_x, got.pixel_y, got.last_point);
      mismatches++;
      return;
    end
    want = owed_points.pop_front();
    if (got.pixel_x !== want.pixel_x) begin
      $display("%0t: pixel_x expected %0d got %0d", $time, want.pixel_x, got.pixel_x);
      mismatches++;
    end
    if (got.pixel_y !== want.pixel_y) begin
      $display("%0t: pixel_y expected %0d got %0d", $time, want.pixel_y, got.pixel_y);
      mismatches++;
    end
    if (got.last_point !== want.last_point) begin
      $display("%0t: last_point expected %0d got %0d", $time,
               want.last_point, got.last_point);
      mismatches++;
    end
  endfunction

  function int owed_count();
    return owed_points.size();
  endfunction
endclass

module tb_dda_line_rasterizer;
  import dda_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 120;
  localparam int LONG_HOLD    = 300;
  localparam int PHASE_ITEMS  = 400;
  localparam int COORD_MAX    = (1 << COORD_BITS_DEF) - 1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready_o;
  req_t req_payload = '0;
  logic out_valid_o;
  logic out_ready = 1'b0;
  pix_t out_o;

  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  int  live_items  = 0;
  int  cycle_count = 0;
  int  rx_hold_left = 0;
  bit  rx_hold_req = 1'b0;

  line_trace_model trace = new();

  dda_line_rasterizer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_i        (req_payload),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_o       (out_o)
  );

  // Clock: 20 ns period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Watch both channels at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) trace.take_request(req_payload);
      if (out_valid_o && out_ready) trace.check_point(out_o);
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Point receiver: random stalls plus one long hold-off on request
  always @(negedge clk_i) begin
    if (rx_hold_left > 0) begin
      out_ready <= 1'b0;
      rx_hold_left--;
    end else if (rx_hold_req) begin
      rx_hold_req  = 1'b0;
      rx_hold_left = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= (int'($urandom_range(99)) >= rx_idle_pct);
    end
  end

  // Offer one request and hold it until the transfer; call at a falling edge
  task automatic send_req(input req_t r);
    while (int'($urandom_range(99)) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid    <= 1'b1;
    req_payload <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_load(input int sx, sy, ex, ey);
    req_t r;
    r.req_type = REQ_LOAD;
    r.start_x  = sx[PIX_W-1:0];
    r.start_y  = sy[PIX_W-1:0];
    r.end_x    = ex[PIX_W-1:0];
    r.end_y    = ey[PIX_W-1:0];
    live_items++;
    send_req(r);
  endtask

  // Tick with random don't-care coordinates; live means a line is in progress
  task automatic send_tick(input bit live);
    req_t        r;
    logic [63:0] raw;
    raw        = {$urandom, $urandom};
    r          = raw[$bits(req_t)-1:0];
    r.req_type = REQ_TICK;
    if (live) live_items++;
    send_req(r);
  endtask

  // Load a line and follow it with a number of ticks
  task automatic drive_line(input int sx, sy, ex, ey, input int n_ticks);
    int adx, ady, steps;
    adx   = (ex > sx) ? ex - sx : sx - ex;
    ady   = (ey > sy) ? ey - sy : sy - ey;
    steps = (adx > ady) ? adx : ady;
    send_load(sx, sy, ex, ey);
    for (int i = 0; i < n_ticks; i++) send_tick(i < steps);
  endtask

  function automatic int pick_coord();
    int k;
    k = $urandom_range(99);
    if (k < 15) return 0;
    if (k < 30) return COORD_MAX;
    return $urandom_range(COORD_MAX);
  endfunction

  function automatic int clamp_coord(input int v);
    if (v < 0) return 0;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  // One random line or an idle tick: mostly short and finished, some long and abandoned
  task automatic random_line();
    int sx, sy, ex, ey, kind, span, adx, ady, steps, n;
    kind = $urandom_range(99);
    if (kind < 5) begin
      send_tick(1'b0);
      return;
    end
    sx = pick_coord();
    sy = pick_coord();
    if (kind < 90) begin
      span = (kind < 70) ? 6 : 64;
      ex = clamp_coord(sx + int'($urandom_range(2 * span)) - span);
      ey = clamp_coord(sy + int'($urandom_range(2 * span)) - span);
    end else begin
      ex = pick_coord();
      ey = pick_coord();
    end
    adx   = (ex > sx) ? ex - sx : sx - ex;
    ady   = (ey > sy) ? ey - sy : sy - ey;
    steps = (adx > ady) ? adx : ady;
    if (kind < 90 && $urandom_range(99) < 80) n = steps + $urandom_range(2);
    else n = $urandom_range((steps < 20) ? steps : 20);
    drive_line(sx, sy, ex, ey, n);
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct);
    int start;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    start = live_items;
    while (live_items - start < PHASE_ITEMS) random_line();
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: idle ticks, zero-length lines, rounding, abandon, extremes
    tx_idle_pct = 13;
    rx_idle_pct = 66;
    send_tick(1'b0);
    drive_line(0, 0, 0, 0, 1);
    drive_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0);
    drive_line(0, 0, 2, 1, 3);
    drive_line(2, 1, 0, 0, 2);
    drive_line(0, COORD_MAX, COORD_MAX, 0, 2);
    drive_line(COORD_MAX, 0, COORD_MAX - 3, 3, 3);
    drive_line(10, 10, 12, 15, 5);

    // Random lines under three stall patterns
    run_phase(13, 66);
    run_phase(66, 13);
    rx_hold_req = 1'b1;
    run_phase(0, 0);
    in_valid <= 1'b0;

    // Drain outstanding points, then give the block time for strays
    while (trace.owed_count() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (trace.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
